// ===== hw/rtl/block_average_pixelate_assert.svh =====
// Assertion macros shared by the block average pixelate RTL.
`ifndef BLOCK_AVERAGE_PIXELATE_ASSERT_SVH
`define BLOCK_AVERAGE_PIXELATE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define BAP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("block_average_pixelate: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define BAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("block_average_pixelate: next-cycle check failed");

`endif

// ===== hw/rtl/bap_pkg.sv =====
// Package with types and constants for the block average pixelate block.
`timescale 1ns / 1ps

package bap_pkg;

   // Image and block limits
   localparam int MAX_WIDTH = 4096;
   localparam int MAX_BLOCK = 64;
   localparam int ROW_LIMIT = 4096;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);
   localparam int BLK_W     = $clog2(MAX_BLOCK);

   // Field widths
   localparam int DIM_W  = 13;
   localparam int BS_W   = 7;
   localparam int POS_W  = 12;
   localparam int COMP_W = 8;
   localparam int SUM_W  = 20;
   localparam int CNT_W  = 13;
   localparam int CSR_W  = 2;
   localparam int STEP_W = $clog2(COMP_W);

   typedef enum logic [CSR_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_BLOCK_SIZE   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   typedef struct packed {
      logic [COMP_W-1:0] pix_red;
      logic [COMP_W-1:0] pix_green;
      logic [COMP_W-1:0] pix_blue;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]  block_col;
      logic [POS_W-1:0]  block_row;
      logic [COMP_W-1:0] avg_red;
      logic [COMP_W-1:0] avg_green;
      logic [COMP_W-1:0] avg_blue;
      logic              image_done;
   } rsp_type;

   typedef struct packed {
      logic [SUM_W-1:0] red_sum;
      logic [SUM_W-1:0] green_sum;
      logic [SUM_W-1:0] blue_sum;
      logic [CNT_W-1:0] pixel_count;
   } accum_type;

endpackage

// ===== hw/rtl/block_average_pixelate.sv =====
// Throughput: 1 pixel per cycle; a pixel that completes a block holds req_ready low
// while the shared 8-step restoring divider runs and until its result is loaded into
// the output register. A block's result passes from stage B through the divider.
// Accumulators live in one 4096-entry memory, read-modify-written in 2 stages.
// Reset (synchronous, active high) clears positions and control; the memory
// needs no clearing pass, as each block's first pixel starts from zero.
`timescale 1ns / 1ps

`include "block_average_pixelate_assert.svh"

module block_average_pixelate import bap_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_index,
   input  logic [DIM_W-1:0] csr_data
);

   // Configuration registers and their clamped values
   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;
   logic [BS_W-1:0]  bs_ff;
   logic [DIM_W-1:0] w_eff;
   logic [DIM_W-1:0] h_eff;
   logic [BS_W-1:0]  bs_eff;
   logic             csr_write;

   // Position counters
   logic [POS_W-1:0] col_pos_ff, col_pos_in;
   logic [POS_W-1:0] row_pos_ff, row_pos_in;
   logic [BLK_W-1:0] col_in_blk_ff, col_in_blk_in;
   logic [BLK_W-1:0] row_in_blk_ff, row_in_blk_in;
   logic [POS_W-1:0] bcol_ff, bcol_in;
   logic [POS_W-1:0] brow_ff, brow_in;

   logic req_accept;
   logic last_col, last_row, col_blk_end, row_blk_end, col_edge, row_edge;
   logic emit, fresh;

   // Stage B (read data back, add, write)
   logic              b_valid_ff;
   logic              b_emit_ff;
   logic              b_fresh_ff;
   logic              b_done_ff;
   logic [ADDR_W-1:0] b_addr_ff;
   logic [POS_W-1:0]  b_brow_ff;
   req_type           b_pix_ff;

   // Accumulator memory and write forwarding
   accum_type         accum_mem [MAX_WIDTH];
   accum_type         rd_data_ff;
   logic              fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   accum_type         fwd_data_ff;
   accum_type         acc_old;
   accum_type         acc_new;
   accum_type         wr_data;
   logic              wr_en;
   logic              div_start;

   // Divider
   div_state_type     div_state_ff, div_state_in;
   logic [STEP_W-1:0] step_ff;
   logic [SUM_W-1:0]  rem_ff [3];
   logic [SUM_W-1:0]  rem_in [3];
   logic [COMP_W-1:0] quo_ff [3];
   logic [COMP_W-1:0] quo_in [3];
   logic [SUM_W-1:0]  dvs_ff;
   rsp_type           info_ff;
   logic              rsp_load;

   // Output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // Clamp configuration into its legal range
   always_comb begin
      if (width_ff == '0) w_eff = DIM_W'(1);
      else if (width_ff > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
      else w_eff = width_ff;
      if (height_ff == '0) h_eff = DIM_W'(1);
      else if (height_ff > DIM_W'(ROW_LIMIT)) h_eff = DIM_W'(ROW_LIMIT);
      else h_eff = height_ff;
      if (bs_ff == '0) bs_eff = BS_W'(1);
      else if (bs_ff > BS_W'(MAX_BLOCK)) bs_eff = BS_W'(MAX_BLOCK);
      else bs_eff = bs_ff;
   end

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && (csr_index == CSR_IMAGE_WIDTH ||
                                    csr_index == CSR_IMAGE_HEIGHT ||
                                    csr_index == CSR_BLOCK_SIZE);

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(1920);
         height_ff <= DIM_W'(1080);
         bs_ff     <= BS_W'(8);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            CSR_BLOCK_SIZE:   bs_ff     <= csr_data[BS_W-1:0];
            default: ;
         endcase
      end
   end

   // Accept a pixel when no block result is on its way through the divider
   assign req_ready  = (div_state_ff == DIV_IDLE) && !(b_valid_ff && b_emit_ff);
   assign req_accept = req_valid && req_ready;

   // Work out block edges for the incoming pixel
   always_comb begin
      last_col    = (DIM_W'(col_pos_ff) + DIM_W'(1)) == w_eff;
      last_row    = (DIM_W'(row_pos_ff) + DIM_W'(1)) == h_eff;
      col_blk_end = (BS_W'(col_in_blk_ff) + BS_W'(1)) == bs_eff;
      row_blk_end = (BS_W'(row_in_blk_ff) + BS_W'(1)) == bs_eff;
      col_edge    = last_col || col_blk_end;
      row_edge    = last_row || row_blk_end;
      emit        = col_edge && row_edge;
      fresh       = (col_in_blk_ff == '0) && (row_in_blk_ff == '0);
   end

   // Advance the raster position
   always_comb begin
      col_pos_in    = col_pos_ff;
      row_pos_in    = row_pos_ff;
      col_in_blk_in = col_in_blk_ff;
      row_in_blk_in = row_in_blk_ff;
      bcol_in       = bcol_ff;
      brow_in       = brow_ff;
      if (last_col) begin
         col_pos_in    = '0;
         col_in_blk_in = '0;
         bcol_in       = '0;
         if (last_row) begin
            row_pos_in    = '0;
            row_in_blk_in = '0;
            brow_in       = '0;
         end else begin
            row_pos_in    = row_pos_ff + POS_W'(1);
            row_in_blk_in = row_blk_end ? '0 : row_in_blk_ff + BLK_W'(1);
            brow_in       = row_blk_end ? brow_ff + POS_W'(1) : brow_ff;
         end
      end else begin
         col_pos_in    = col_pos_ff + POS_W'(1);
         col_in_blk_in = col_blk_end ? '0 : col_in_blk_ff + BLK_W'(1);
         bcol_in       = col_blk_end ? bcol_ff + POS_W'(1) : bcol_ff;
      end
   end

   // Hold position counters; restart the image on a register write
   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         col_pos_ff    <= '0;
         row_pos_ff    <= '0;
         col_in_blk_ff <= '0;
         row_in_blk_ff <= '0;
         bcol_ff       <= '0;
         brow_ff       <= '0;
      end else if (req_accept) begin
         col_pos_ff    <= col_pos_in;
         row_pos_ff    <= row_pos_in;
         col_in_blk_ff <= col_in_blk_in;
         row_in_blk_ff <= row_in_blk_in;
         bcol_ff       <= bcol_in;
         brow_ff       <= brow_in;
      end
   end

   // Pass the pixel on to stage B
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= req_accept;
      end
      if (req_accept) begin
         b_emit_ff  <= emit;
         b_fresh_ff <= fresh;
         b_done_ff  <= last_col && last_row;
         b_addr_ff  <= bcol_ff[ADDR_W-1:0];
         b_brow_ff  <= brow_ff;
         b_pix_ff   <= req_data;
      end
   end

   // Select the old entry: zero at a block's first pixel, else forward or memory
   always_comb begin
      if (b_fresh_ff) acc_old = '0;
      else if (fwd_valid_ff && (fwd_addr_ff == b_addr_ff)) acc_old = fwd_data_ff;
      else acc_old = rd_data_ff;
      acc_new.red_sum     = acc_old.red_sum + SUM_W'(b_pix_ff.pix_red);
      acc_new.green_sum   = acc_old.green_sum + SUM_W'(b_pix_ff.pix_green);
      acc_new.blue_sum    = acc_old.blue_sum + SUM_W'(b_pix_ff.pix_blue);
      acc_new.pixel_count = acc_old.pixel_count + CNT_W'(1);
      wr_en     = b_valid_ff;
      wr_data   = b_emit_ff ? '0 : acc_new;
      div_start = b_valid_ff && b_emit_ff;
   end

   // Read and write the accumulator memory
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= accum_mem[bcol_ff[ADDR_W-1:0]];
      end
      if (wr_en) begin
         accum_mem[b_addr_ff] <= wr_data;
      end
   end

   // Remember the last write for a read of the same entry in that cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= wr_en;
      end
      fwd_addr_ff <= b_addr_ff;
      fwd_data_ff <= wr_data;
   end

   // Divider control
   always_ff @(posedge clock) begin
      if (reset) begin
         div_state_ff <= DIV_IDLE;
      end else begin
         div_state_ff <= div_state_in;
      end
   end

   always_comb begin
      div_state_in = div_state_ff;
      rsp_load     = 1'b0;
      case (div_state_ff)
         DIV_IDLE: begin
            if (div_start) div_state_in = DIV_RUN;
         end
         DIV_RUN: begin
            if (step_ff == '0) div_state_in = DIV_DONE;
         end
         DIV_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
            if (rsp_load) div_state_in = DIV_IDLE;
         end
         default: div_state_in = DIV_IDLE;
      endcase
   end

   // One restoring step per cycle on each colour
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (rem_ff[i] >= dvs_ff) begin
            rem_in[i] = rem_ff[i] - dvs_ff;
            quo_in[i] = {quo_ff[i][COMP_W-2:0], 1'b1};
         end else begin
            rem_in[i] = rem_ff[i];
            quo_in[i] = {quo_ff[i][COMP_W-2:0], 1'b0};
         end
      end
   end

   // Load the divider from stage B, then iterate
   always_ff @(posedge clock) begin
      if (div_start) begin
         rem_ff[0] <= acc_new.red_sum;
         rem_ff[1] <= acc_new.green_sum;
         rem_ff[2] <= acc_new.blue_sum;
         for (int i = 0; i < 3; i++) begin
            quo_ff[i] <= '0;
         end
         dvs_ff  <= SUM_W'({acc_new.pixel_count, {(COMP_W-1){1'b0}}});
         step_ff <= STEP_W'(COMP_W - 1);
         info_ff.block_col  <= POS_W'(b_addr_ff);
         info_ff.block_row  <= b_brow_ff;
         info_ff.avg_red    <= '0;
         info_ff.avg_green  <= '0;
         info_ff.avg_blue   <= '0;
         info_ff.image_done <= b_done_ff;
      end else if (div_state_ff == DIV_RUN) begin
         for (int i = 0; i < 3; i++) begin
            rem_ff[i] <= rem_in[i];
            quo_ff[i] <= quo_in[i];
         end
         dvs_ff  <= dvs_ff >> 1;
         step_ff <= step_ff - STEP_W'(1);
      end
   end

   // Hold the result until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_data_ff <= '{block_col:  info_ff.block_col,
                          block_row:  info_ff.block_row,
                          avg_red:    quo_ff[0],
                          avg_green:  quo_ff[1],
                          avg_blue:   quo_ff[2],
                          image_done: info_ff.image_done};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `BAP_ASSERT_IMPL(a_start_when_idle, clock, reset, div_start, div_state_ff == DIV_IDLE)
   `BAP_ASSERT_IMPL(a_stall_while_dividing, clock, reset, div_state_ff != DIV_IDLE, !req_ready)
   `BAP_ASSERT_NEXT(a_accept_reaches_b, clock, reset, req_valid && req_ready, b_valid_ff)
   `BAP_ASSERT_IMPL(a_offsets_in_block, clock, reset, 1'b1, (BS_W'(col_in_blk_ff) < bs_eff) && (BS_W'(row_in_blk_ff) < bs_eff))
   `BAP_ASSERT_NEXT(a_load_frees_divider, clock, reset, rsp_load, rsp_valid_ff && (div_state_ff == DIV_IDLE))

endmodule

// ===== tb/sv/block_average_pixelate_tb.sv =====
// Self-checking testbench for the block average pixelate block.
`timescale 1ns / 1ps

module block_average_pixelate_tb;
   import bap_pkg::*;

   localparam int RST_WIDTH  = 1920;
   localparam int RST_HEIGHT = 1080;
   localparam int RST_BSIZE  = 8;
   localparam int SETTLE_CYC = 16;
   localparam int DRAIN_CYC  = 30;
   localparam int HOLD_CYC   = 400;
   localparam int SAT_ITEMS  = 128;
   localparam int RAND_ITEMS = 1460;
   localparam logic [CSR_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic {ROW_REG, ROW_PIX} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [CSR_W-1:0]  idx;
      logic [DIM_W-1:0]  val;
      req_type           pix;
      bit                typed;
      rsp_type           typed_blk;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_index = '0;
   logic [DIM_W-1:0] csr_data = '0;

   // Shadow of the block: registers, raster position and column accumulators
   logic [DIM_W-1:0] cfg_width  = DIM_W'(RST_WIDTH);
   logic [DIM_W-1:0] cfg_height = DIM_W'(RST_HEIGHT);
   logic [BS_W-1:0]  cfg_bsize  = BS_W'(RST_BSIZE);
   int unsigned      at_col = 0;
   int unsigned      at_row = 0;
   logic [SUM_W-1:0] acc_red   [MAX_WIDTH];
   logic [SUM_W-1:0] acc_green [MAX_WIDTH];
   logic [SUM_W-1:0] acc_blue  [MAX_WIDTH];
   logic [CNT_W-1:0] acc_count [MAX_WIDTH];

   rsp_type      pending_blocks[$];
   stim_row_type stim_tab[$];
   int           fail_count = 0;
   int           send_idle_pct = 0;
   int           rcv_stall_pct = 0;
   int           hold_asked = 0;

   block_average_pixelate dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Give up on a hung run
   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic rsp_type blk_of(input int col, input int row, input logic [7:0] r,
                                      input logic [7:0] g, input logic [7:0] b,
                                      input logic done);
      rsp_type t;
      t.block_col  = POS_W'(col);
      t.block_row  = POS_W'(row);
      t.avg_red    = r;
      t.avg_green  = g;
      t.avg_blue   = b;
      t.image_done = done;
      return t;
   endfunction

   function automatic logic [COMP_W-1:0] rand_comp();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return COMP_W'($urandom_range(255));
      endcase
   endfunction

   function automatic req_type rand_pixel();
      req_type p;
      p.pix_red   = rand_comp();
      p.pix_green = rand_comp();
      p.pix_blue  = rand_comp();
      return p;
   endfunction

   function automatic void add_reg(input logic [CSR_W-1:0] idx, input int val);
      stim_row_type row;
      row.kind      = ROW_REG;
      row.idx       = idx;
      row.val       = DIM_W'(val);
      row.pix       = '0;
      row.typed     = 1'b0;
      row.typed_blk = '0;
      stim_tab.push_back(row);
   endfunction

   function automatic void add_pix(input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b, input bit typed, input rsp_type blk);
      stim_row_type row;
      row.kind      = ROW_PIX;
      row.idx       = '0;
      row.val       = '0;
      row.pix       = '{pix_red: r, pix_green: g, pix_blue: b};
      row.typed     = typed;
      row.typed_blk = blk;
      stim_tab.push_back(row);
   endfunction

   // Restart the image: back to the origin with every accumulator empty
   task automatic restart_image();
      at_col = 0;
      at_row = 0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         acc_red[i]   = '0;
         acc_green[i] = '0;
         acc_blue[i]  = '0;
         acc_count[i] = '0;
      end
   endtask

   task automatic apply_reg(input logic [CSR_W-1:0] idx, input logic [DIM_W-1:0] val);
      bit hit;
      hit = 1'b1;
      case (idx)
         CSR_IMAGE_WIDTH:  cfg_width  = val;
         CSR_IMAGE_HEIGHT: cfg_height = val;
         CSR_BLOCK_SIZE:   cfg_bsize  = val[BS_W-1:0];
         default:          hit = 1'b0;
      endcase
      if (hit) restart_image();
   endtask

   // Accumulate one pixel and work out the block average it completes, if any
   task automatic predict_block(input req_type p, output bit done_blk, output rsp_type blk);
      int unsigned w, h, bs, bc, n;
      bit last_col, last_row;
      w  = clamp_dim(cfg_width, MAX_WIDTH);
      h  = clamp_dim(cfg_height, ROW_LIMIT);
      bs = clamp_dim(cfg_bsize, MAX_BLOCK);
      done_blk = 1'b0;
      blk = '0;
      if (at_col >= w) at_col = 0;
      if (at_row >= h) at_row = 0;
      bc = at_col / bs;
      acc_red[bc]   += p.pix_red;
      acc_green[bc] += p.pix_green;
      acc_blue[bc]  += p.pix_blue;
      acc_count[bc] += 1'b1;
      last_col = (at_col + 1 == w);
      last_row = (at_row + 1 == h);
      if ((last_col || (at_col + 1) % bs == 0) && (last_row || (at_row + 1) % bs == 0)) begin
         n = acc_count[bc];
         blk.block_col  = POS_W'(bc);
         blk.block_row  = POS_W'(at_row / bs);
         blk.avg_red    = COMP_W'(acc_red[bc] / n);
         blk.avg_green  = COMP_W'(acc_green[bc] / n);
         blk.avg_blue   = COMP_W'(acc_blue[bc] / n);
         blk.image_done = last_col && last_row;
         acc_red[bc]   = '0;
         acc_green[bc] = '0;
         acc_blue[bc]  = '0;
         acc_count[bc] = '0;
         done_blk = 1'b1;
      end
      if (last_col) begin
         at_col = 0;
         at_row = last_row ? 0 : at_row + 1;
      end else begin
         at_col = at_col + 1;
      end
   endtask

   // Offer one pixel, with an optional gap first; predict on transfer
   task automatic send_pixel(input req_type p, input bit typed, input rsp_type typed_blk);
      bit      done_blk;
      rsp_type blk;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_block(p, done_blk, blk);
      if (typed) pending_blocks.push_back(typed_blk);
      else if (done_blk) pending_blocks.push_back(blk);
   endtask

   task automatic run_pixels(input int n);
      for (int i = 0; i < n; i++) send_pixel(rand_pixel(), 1'b0, '0);
   endtask

   // Drop valid, drain every expected block, then let the pipeline empty
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_blocks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_W-1:0] idx, input int val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= DIM_W'(val);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      apply_reg(idx, DIM_W'(val));
   endtask

   // Result side: random stalls, plus a long hold-off on request
   initial begin
      int hold_left;
      int hold_served;
      hold_left = 0;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = HOLD_CYC;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
         end
      end
   end

   // Check each transferred block against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_blocks.size() == 0) begin
            if (fail_count < 10)
               $display("unexpected block: col %0d row %0d rgb %02h %02h %02h done %0b",
                        rsp_data.block_col, rsp_data.block_row, rsp_data.avg_red,
                        rsp_data.avg_green, rsp_data.avg_blue, rsp_data.image_done);
            fail_count++;
         end else begin
            want = pending_blocks.pop_front();
            if (rsp_data.block_col !== want.block_col || rsp_data.block_row !== want.block_row
                || rsp_data.avg_red !== want.avg_red || rsp_data.avg_green !== want.avg_green
                || rsp_data.avg_blue !== want.avg_blue
                || rsp_data.image_done !== want.image_done) begin
               if (fail_count < 10)
                  $display("block mismatch: want col %0d row %0d rgb %02h %02h %02h done %0b, got col %0d row %0d rgb %02h %02h %02h done %0b",
                           want.block_col, want.block_row, want.avg_red, want.avg_green,
                           want.avg_blue, want.image_done, rsp_data.block_col,
                           rsp_data.block_row, rsp_data.avg_red, rsp_data.avg_green,
                           rsp_data.avg_blue, rsp_data.image_done);
               fail_count++;
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      int           n, phase, rand_items;
      int unsigned  img;

      restart_image();

      // Directed: reset dimensions, then a partial image thrown away by a write
      add_pix(8'h12, 8'h34, 8'h56, 1'b0, '0);
      add_pix(8'hFF, 8'hFF, 8'hFF, 1'b0, '0);
      // One row at the reset width: the reset block size closes a block after 8
      add_reg(CSR_IMAGE_HEIGHT, 1);
      for (int i = 0; i < 8; i++)
         add_pix(8'(1 << i), 8'(~(1 << i)), 8'(i * 37), 1'b0, '0);
      // Zero dimensions act as one: every pixel is a whole image
      add_reg(CSR_IMAGE_WIDTH, 0);
      add_reg(CSR_IMAGE_HEIGHT, 0);
      add_reg(CSR_BLOCK_SIZE, 0);
      add_pix(8'hFF, 8'h00, 8'h80, 1'b1, blk_of(0, 0, 8'hFF, 8'h00, 8'h80, 1'b1));
      add_pix(8'h00, 8'hFF, 8'h7F, 1'b1, blk_of(0, 0, 8'h00, 8'hFF, 8'h7F, 1'b1));
      // Two-pixel block: averages truncate
      add_reg(CSR_IMAGE_WIDTH, 2);
      add_reg(CSR_BLOCK_SIZE, 2);
      add_pix(8'hFF, 8'h00, 8'h01, 1'b0, '0);
      add_pix(8'h00, 8'hFF, 8'h00, 1'b1, blk_of(0, 0, 8'h7F, 8'h7F, 8'h00, 1'b1));
      // Oversized block saturates; a write to an unused index leaves the image alone
      add_reg(CSR_BLOCK_SIZE, 127);
      add_reg(CSR_IMAGE_WIDTH, 3);
      add_pix(8'hAA, 8'h55, 8'hFF, 1'b0, '0);
      add_reg(CSR_UNUSED, 1);
      add_pix(8'h55, 8'hAA, 8'h00, 1'b0, '0);
      add_pix(8'h01, 8'h02, 8'h03, 1'b0, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_tab[i]) begin
         row = stim_tab[i];
         if (row.kind == ROW_REG) begin
            settle_block();
            write_reg(row.idx, row.val);
         end else begin
            send_pixel(row.pix, row.typed, row.typed_blk);
         end
      end

      // Width beyond the limit saturates: keep closing blocks along the first row
      settle_block();
      write_reg(CSR_IMAGE_WIDTH, 8191);
      write_reg(CSR_IMAGE_HEIGHT, 1);
      write_reg(CSR_BLOCK_SIZE, 64);
      run_pixels(SAT_ITEMS);

      // Height beyond the limit saturates likewise, one pixel per row
      settle_block();
      write_reg(CSR_IMAGE_WIDTH, 1);
      write_reg(CSR_IMAGE_HEIGHT, 8191);
      write_reg(CSR_BLOCK_SIZE, 100);
      run_pixels(SAT_ITEMS);

      // Hold the result side off while pixels keep coming, so the input backs up
      settle_block();
      write_reg(CSR_IMAGE_WIDTH, 16);
      write_reg(CSR_IMAGE_HEIGHT, 4);
      write_reg(CSR_BLOCK_SIZE, 1);
      hold_asked++;
      run_pixels(64);

      // Random phases: mostly whole small images, some odd register values
      rand_items = 0;
      phase = 0;
      while (rand_items < RAND_ITEMS) begin
         settle_block();
         case (phase % 4)
            0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; rcv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rcv_stall_pct = 68; end
            default: begin send_idle_pct = 30; rcv_stall_pct = 30; end
         endcase
         if ($urandom_range(9) == 0) begin
            if ($urandom_range(1)) write_reg(CSR_IMAGE_WIDTH, $urandom_range(8191));
            if ($urandom_range(1)) write_reg(CSR_IMAGE_HEIGHT, $urandom_range(8191));
            if ($urandom_range(1)) write_reg(CSR_BLOCK_SIZE, $urandom_range(8191));
         end else begin
            if ($urandom_range(3) != 0) write_reg(CSR_IMAGE_WIDTH, $urandom_range(1, 24));
            if ($urandom_range(3) != 0) write_reg(CSR_IMAGE_HEIGHT, $urandom_range(1, 8));
            if ($urandom_range(3) != 0)
               write_reg(CSR_BLOCK_SIZE, ($urandom_range(3) == 0) ? $urandom_range(1, 64)
                                                                   : $urandom_range(1, 6));
         end
         img = clamp_dim(cfg_width, MAX_WIDTH) * clamp_dim(cfg_height, ROW_LIMIT);
         if (img <= 150) n = img * $urandom_range(1, 2) + $urandom_range(0, img);
         else n = $urandom_range(20, 150);
         run_pixels(n);
         rand_items += n;
         phase++;
      end

      // Drain and finish
      req_valid <= 1'b0;
      while (pending_blocks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bap_pkg.sv
hw/rtl/block_average_pixelate.sv
tb/sv/block_average_pixelate_tb.sv
